FILE: rtl/core/tvc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tvc_pkg: shared definitions for the truth value combiner
// Q1.15 constants, operation codes, stage payload types and the small
// fixed-point helpers used across the pipeline.
// ============================================================================
package tvc_pkg;

    localparam logic [15:0] Q_ONE           = 16'd32768;
    localparam logic [15:0] Q_HALF          = 16'd16384;
    localparam logic [16:0] SMALL_DENOM     = 17'd4;
    localparam logic [16:0] DS_CONFLICT_MAX = 17'd32440;
    localparam logic [18:0] DS_EPS          = 19'd3;
    localparam logic [15:0] ABDUCT_SCALE    = 16'd9830;

    localparam logic [3:0] CMD_HICONF = 4'd0;
    localparam logic [3:0] CMD_LOCONF = 4'd1;
    localparam logic [3:0] CMD_WAVG   = 4'd2;
    localparam logic [3:0] CMD_REVISE = 4'd3;
    localparam logic [3:0] CMD_DS     = 4'd4;
    localparam logic [3:0] CMD_MAXS   = 4'd5;
    localparam logic [3:0] CMD_MINS   = 4'd6;
    localparam logic [3:0] CMD_DEDUCT = 4'd7;
    localparam logic [3:0] CMD_INDUCT = 4'd8;
    localparam logic [3:0] CMD_ABDUCT = 4'd9;

    // First divider: three lanes (weighted average, revision or belief;
    // disbelief; uncertainty). Second divider: the final belief ratio.
    localparam int DIV1_LANES = 3;
    localparam int DIV1_DW    = 33;
    localparam int DIV1_VW    = 17;
    localparam int DIV1_QW    = 18;
    localparam int DIV2_LANES = 1;
    localparam int DIV2_DW    = 33;
    localparam int DIV2_VW    = 19;
    localparam int DIV2_QW    = 16;

    // Partial result that travels alongside the dividers.
    typedef struct packed {
        logic [3:0]  cmd;
        logic        fb;
        logic [15:0] res_s;
        logic [15:0] res_c;
    } tvc_side_t;

    // Finished result as held in the output register and the skid stage.
    typedef struct packed {
        logic        fb;
        logic [15:0] res_s;
        logic [15:0] res_c;
    } tvc_res_t;

    function automatic logic [15:0] sat_q(input logic [15:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    function automatic logic [15:0] sat17(input logic [16:0] v);
        return (v > {1'b0, Q_ONE}) ? Q_ONE : v[15:0];
    endfunction

    // Truncating Q1.15 product of two values no larger than one.
    function automatic logic [15:0] qmul(input logic [15:0] x, input logic [15:0] y);
        logic [31:0] p;
        p = 32'(x) * 32'(y);
        return p[30:15];
    endfunction

endpackage

FILE: rtl/core/truth_value_combiner.sv
`timescale 1ns / 1ps
// ============================================================================
// truth_value_combiner: pipelined combiner of two Q1.15 truth values
// Selects, averages, revises, fuses or infers from (strength, confidence) pairs.
// ============================================================================
// Usage:
// The input channel carries one transaction per operation: an operation code
// and two (strength, confidence) pairs in unsigned Q1.15, where 32768 is one.
// Operands above one are saturated on entry. The output channel returns one
// transaction per input: the combined pair, clamped to one, and a fallback
// flag for a degenerate denominator or near-total Dempster-Shafer conflict.
// A transaction passes four arithmetic stages, an 18-stage three-lane
// divider, one add stage, a 16-stage divider and the output register. The
// dividers retire one quotient bit per stage, which sets this depth.
// Throughput is one transaction per cycle while the skid stage is empty.
// Reset clears every valid bit; the block then accepts input at once.
// When the receiver stalls, the output register holds its result and a
// one-entry skid stage takes the next finished transaction; only once the
// skid stage is full does in_ready fall and the whole pipeline freeze,
// so nothing is lost or repeated.
// ============================================================================
module truth_value_combiner
    import tvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cmd,
    input  logic [15:0] strength_a,
    input  logic [15:0] conf_a,
    input  logic [15:0] strength_b,
    input  logic [15:0] conf_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_strength,
    output logic [15:0] out_conf,
    output logic        fallback
);

    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    // The pipeline advances as a whole unless the skid stage is occupied.
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stage 0: register and saturate the operands.
    // ------------------------------------------------------------------
    logic        s0_valid_reg;
    logic [3:0]  s0_cmd_reg;
    logic [15:0] s0_sa_reg, s0_ca_reg, s0_sb_reg, s0_cb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_cmd_reg <= cmd;
            s0_sa_reg  <= sat_q(strength_a);
            s0_ca_reg  <= sat_q(conf_a);
            s0_sb_reg  <= sat_q(strength_b);
            s0_cb_reg  <= sat_q(conf_b);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: first level of products. The full products of strength and
    // confidence feed the weighted average; their upper bits are the beliefs.
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [3:0]  s1_cmd_reg;
    logic [15:0] s1_sa_reg, s1_ca_reg, s1_sb_reg, s1_cb_reg;
    logic [31:0] s1_p_saca_reg, s1_p_sbcb_reg;
    logic [15:0] s1_q_sasb_reg, s1_q_cacb_reg, s1_dis1_reg, s1_dis2_reg, s1_q_nn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg    <= s0_cmd_reg;
            s1_sa_reg     <= s0_sa_reg;
            s1_ca_reg     <= s0_ca_reg;
            s1_sb_reg     <= s0_sb_reg;
            s1_cb_reg     <= s0_cb_reg;
            s1_p_saca_reg <= 32'(s0_sa_reg) * 32'(s0_ca_reg);
            s1_p_sbcb_reg <= 32'(s0_sb_reg) * 32'(s0_cb_reg);
            s1_q_sasb_reg <= qmul(s0_sa_reg, s0_sb_reg);
            s1_q_cacb_reg <= qmul(s0_ca_reg, s0_cb_reg);
            s1_dis1_reg   <= qmul(Q_ONE - s0_sa_reg, s0_ca_reg);
            s1_dis2_reg   <= qmul(Q_ONE - s0_sb_reg, s0_cb_reg);
            s1_q_nn_reg   <= qmul(Q_ONE - s0_sa_reg, Q_ONE - s0_sb_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: second level of products for revision, evidence fusion and
    // abduction, plus the weighted-average numerator and weight.
    // ------------------------------------------------------------------
    logic [15:0] bel1, bel2, unc1, unc2;

    assign bel1 = s1_p_saca_reg[30:15];
    assign bel2 = s1_p_sbcb_reg[30:15];
    assign unc1 = Q_ONE - s1_ca_reg;
    assign unc2 = Q_ONE - s1_cb_reg;

    logic        s2_valid_reg;
    logic [3:0]  s2_cmd_reg;
    logic [15:0] s2_sa_reg, s2_ca_reg, s2_sb_reg, s2_cb_reg;
    logic [15:0] s2_q_sasb_reg, s2_q_cacb_reg, s2_q_nn_reg, s2_q_ab_reg;
    logic [31:0] s2_t1_reg, s2_t2_reg, s2_t3_reg, s2_wnum_reg;
    logic [16:0] s2_d_reg, s2_tw_reg;
    logic [15:0] s2_k1_reg, s2_k2_reg;
    logic [15:0] s2_bb_reg, s2_bu_reg, s2_ub_reg;
    logic [15:0] s2_dd_reg, s2_du_reg, s2_ud_reg, s2_uu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_sa_reg     <= s1_sa_reg;
            s2_ca_reg     <= s1_ca_reg;
            s2_sb_reg     <= s1_sb_reg;
            s2_cb_reg     <= s1_cb_reg;
            s2_q_sasb_reg <= s1_q_sasb_reg;
            s2_q_cacb_reg <= s1_q_cacb_reg;
            s2_q_nn_reg   <= s1_q_nn_reg;
            s2_q_ab_reg   <= qmul(s1_q_cacb_reg, ABDUCT_SCALE);
            s2_t1_reg     <= 32'(bel1) * 32'(unc2);
            s2_t2_reg     <= 32'(bel2) * 32'(unc1);
            s2_t3_reg     <= 32'(s1_q_sasb_reg) * 32'(s1_q_cacb_reg);
            s2_wnum_reg   <= s1_p_saca_reg + s1_p_sbcb_reg;
            s2_d_reg      <= 17'(s1_ca_reg) + 17'(s1_cb_reg) - 17'(s1_q_cacb_reg);
            s2_tw_reg     <= 17'(s1_ca_reg) + 17'(s1_cb_reg);
            s2_k1_reg     <= qmul(bel1, s1_dis2_reg);
            s2_k2_reg     <= qmul(s1_dis1_reg, bel2);
            s2_bb_reg     <= qmul(bel1, bel2);
            s2_bu_reg     <= qmul(bel1, unc2);
            s2_ub_reg     <= qmul(unc1, bel2);
            s2_dd_reg     <= qmul(s1_dis1_reg, s1_dis2_reg);
            s2_du_reg     <= qmul(s1_dis1_reg, unc2);
            s2_ud_reg     <= qmul(unc1, s1_dis2_reg);
            s2_uu_reg     <= qmul(unc1, unc2);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums, fallback decisions, the direct results of the simple
    // operations, and the operands for the first divider.
    // ------------------------------------------------------------------
    logic [31:0] rev_num;
    logic [16:0] ds_k, ds_n;
    logic [17:0] x_bel, x_dis;
    logic [15:0] mean_s;
    tvc_side_t   s3_side_next;
    logic [DIV1_LANES-1:0][DIV1_DW-1:0] s3_dvd_next;
    logic [DIV1_LANES-1:0][DIV1_VW-1:0] s3_dvs_next;

    assign rev_num = s2_t1_reg + s2_t2_reg + s2_t3_reg;
    assign ds_k    = 17'(s2_k1_reg) + 17'(s2_k2_reg);
    assign ds_n    = {1'b0, Q_ONE} - ds_k;
    assign x_bel   = 18'(s2_bb_reg) + 18'(s2_bu_reg) + 18'(s2_ub_reg);
    assign x_dis   = 18'(s2_dd_reg) + 18'(s2_du_reg) + 18'(s2_ud_reg);
    assign mean_s  = 16'((17'(s2_sa_reg) + 17'(s2_sb_reg)) >> 1);

    always_comb
    begin
        s3_side_next.cmd   = s2_cmd_reg;
        s3_side_next.fb    = 1'b0;
        s3_side_next.res_s = s2_sa_reg;
        s3_side_next.res_c = s2_ca_reg;
        // Lanes that an operation does not use divide zero by one.
        for (int l = 0; l < DIV1_LANES; l++)
        begin
            s3_dvd_next[l] = '0;
            s3_dvs_next[l] = 17'd1;
        end
        unique case (s2_cmd_reg)
            CMD_HICONF:
            begin
                if (!(s2_ca_reg > s2_cb_reg))
                begin
                    s3_side_next.res_s = s2_sb_reg;
                    s3_side_next.res_c = s2_cb_reg;
                end
            end
            CMD_LOCONF:
            begin
                if (!(s2_ca_reg < s2_cb_reg))
                begin
                    s3_side_next.res_s = s2_sb_reg;
                    s3_side_next.res_c = s2_cb_reg;
                end
            end
            CMD_MAXS:
            begin
                if (!(s2_sa_reg > s2_sb_reg))
                begin
                    s3_side_next.res_s = s2_sb_reg;
                    s3_side_next.res_c = s2_cb_reg;
                end
            end
            CMD_MINS:
            begin
                if (!(s2_sa_reg < s2_sb_reg))
                begin
                    s3_side_next.res_s = s2_sb_reg;
                    s3_side_next.res_c = s2_cb_reg;
                end
            end
            CMD_WAVG:
            begin
                if (s2_tw_reg < SMALL_DENOM)
                begin
                    s3_side_next.res_s = mean_s;
                    s3_side_next.res_c = '0;
                    s3_side_next.fb    = 1'b1;
                end
                else
                begin
                    s3_side_next.res_c = (s2_ca_reg > s2_cb_reg) ? s2_ca_reg : s2_cb_reg;
                    s3_dvd_next[0]     = 33'(s2_wnum_reg);
                    s3_dvs_next[0]     = s2_tw_reg;
                end
            end
            CMD_REVISE:
            begin
                if (s2_d_reg < SMALL_DENOM)
                begin
                    s3_side_next.res_s = mean_s;
                    s3_side_next.res_c = '0;
                    s3_side_next.fb    = 1'b1;
                end
                else
                begin
                    s3_side_next.res_c = sat17(s2_d_reg);
                    s3_dvd_next[0]     = 33'(rev_num);
                    s3_dvs_next[0]     = s2_d_reg;
                end
            end
            CMD_DS:
            begin
                if (ds_k > DS_CONFLICT_MAX)
                begin
                    s3_side_next.res_s = Q_HALF;
                    s3_side_next.res_c = '0;
                    s3_side_next.fb    = 1'b1;
                end
                else
                begin
                    s3_dvd_next[0] = 33'({x_bel, 15'd0});
                    s3_dvs_next[0] = ds_n;
                    s3_dvd_next[1] = 33'({x_dis, 15'd0});
                    s3_dvs_next[1] = ds_n;
                    s3_dvd_next[2] = 33'({s2_uu_reg, 15'd0});
                    s3_dvs_next[2] = ds_n;
                end
            end
            CMD_DEDUCT:
            begin
                s3_side_next.res_s = s2_q_sasb_reg;
                s3_side_next.res_c = s2_q_cacb_reg;
            end
            CMD_INDUCT:
            begin
                s3_side_next.res_s = sat17(17'(s2_q_sasb_reg) + 17'(s2_q_nn_reg));
                s3_side_next.res_c = s2_q_cacb_reg >> 1;
            end
            CMD_ABDUCT:
            begin
                s3_side_next.res_s = s2_q_sasb_reg;
                s3_side_next.res_c = s2_q_ab_reg;
            end
            default:
            begin
                // Unknown codes pass operand A through.
            end
        endcase
    end

    logic                               s3_valid_reg;
    tvc_side_t                          s3_side_reg;
    logic [DIV1_LANES-1:0][DIV1_DW-1:0] s3_dvd_reg;
    logic [DIV1_LANES-1:0][DIV1_VW-1:0] s3_dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s3_side_next;
            s3_dvd_reg  <= s3_dvd_next;
            s3_dvs_reg  <= s3_dvs_next;
        end
    end

    // ------------------------------------------------------------------
    // First divider: lane 0 gives the weighted average, the revised
    // strength or the combined belief; lanes 1 and 2 give the combined
    // disbelief and uncertainty.
    // ------------------------------------------------------------------
    logic                               div1_valid;
    logic [DIV1_LANES-1:0][DIV1_QW-1:0] div1_q;
    tvc_side_t                          div1_side;

    tvc_div #(
        .LANES (DIV1_LANES),
        .DW    (DIV1_DW),
        .VW    (DIV1_VW),
        .QW    (DIV1_QW),
        .SW    ($bits(tvc_side_t))
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_dvd_reg),
        .divisor   (s3_dvs_reg),
        .side_in   (s3_side_reg),
        .out_valid (div1_valid),
        .quotient  (div1_q),
        .side_out  (div1_side)
    );

    // ------------------------------------------------------------------
    // Stage 4: fold in the first quotients and form the operands of the
    // final belief ratio.
    // ------------------------------------------------------------------
    tvc_side_t s4_side_next;

    always_comb
    begin
        s4_side_next = div1_side;
        if (!div1_side.fb && (div1_side.cmd == CMD_WAVG || div1_side.cmd == CMD_REVISE))
        begin
            s4_side_next.res_s = (div1_q[0] > 18'(Q_ONE)) ? Q_ONE : div1_q[0][15:0];
        end
        if (!div1_side.fb && div1_side.cmd == CMD_DS)
        begin
            // Confidence is one minus the combined uncertainty, floored at zero.
            s4_side_next.res_c = (div1_q[2] > 18'(Q_ONE)) ? 16'd0 : Q_ONE - div1_q[2][15:0];
        end
    end

    logic                               s4_valid_reg;
    tvc_side_t                          s4_side_reg;
    logic [DIV2_LANES-1:0][DIV2_DW-1:0] s4_dvd_reg;
    logic [DIV2_LANES-1:0][DIV2_VW-1:0] s4_dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= div1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg   <= s4_side_next;
            s4_dvd_reg[0] <= 33'({div1_q[0], 15'd0});
            s4_dvs_reg[0] <= 19'(div1_q[0]) + 19'(div1_q[1]) + DS_EPS;
        end
    end

    // ------------------------------------------------------------------
    // Second divider: combined strength of the evidence fusion.
    // ------------------------------------------------------------------
    logic                               div2_valid;
    logic [DIV2_LANES-1:0][DIV2_QW-1:0] div2_q;
    tvc_side_t                          div2_side;

    tvc_div #(
        .LANES (DIV2_LANES),
        .DW    (DIV2_DW),
        .VW    (DIV2_VW),
        .QW    (DIV2_QW),
        .SW    ($bits(tvc_side_t))
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .dividend  (s4_dvd_reg),
        .divisor   (s4_dvs_reg),
        .side_in   (s4_side_reg),
        .out_valid (div2_valid),
        .quotient  (div2_q),
        .side_out  (div2_side)
    );

    tvc_res_t fin;

    always_comb
    begin
        fin.fb    = div2_side.fb;
        fin.res_s = div2_side.res_s;
        fin.res_c = div2_side.res_c;
        if (!div2_side.fb && div2_side.cmd == CMD_DS)
        begin
            fin.res_s = div2_q[0];
        end
    end

    // ------------------------------------------------------------------
    // Output register with a one-entry skid stage. A result pushed while the
    // output register is stalled lands in the skid stage, which freezes the
    // pipeline until the receiver takes the output transaction.
    // ------------------------------------------------------------------
    tvc_res_t out_data_reg;
    tvc_res_t skid_data_reg;
    logic     push;
    logic     pop;

    assign push = en && div2_valid;
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_data_reg <= fin;
            end
            else
            begin
                out_data_reg <= fin;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_strength = out_data_reg.res_s;
    assign out_conf     = out_data_reg.res_c;
    assign fallback     = out_data_reg.fb;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg)
        else $error("skid stage not drained after the output transaction");

    a_fallback_conf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.fb |-> out_data_reg.res_c == 16'd0)
        else $error("fallback result with nonzero confidence");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.res_s <= Q_ONE) && (out_data_reg.res_c <= Q_ONE))
        else $error("result above one");

endmodule

FILE: rtl/core/tvc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// tvc_div: pipelined restoring divider
// One quotient bit per register stage, several independent lanes in step,
// and a side payload that travels with each transaction.
// ============================================================================
module tvc_div #(
    parameter int LANES = 1,
    parameter int DW    = 33,
    parameter int VW    = 17,
    parameter int QW    = 18,
    parameter int SW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][DW-1:0]   dividend,
    input  logic [LANES-1:0][VW-1:0]   divisor,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   quotient,
    output logic [SW-1:0]              side_out
);

    // The quotient must fit in QW bits; the remainder is wide enough to
    // hold the divisor shifted up to the top quotient bit.
    localparam int WW = (DW > VW + QW) ? DW : VW + QW;

    logic                      valid_reg [QW];
    logic [LANES-1:0][WW-1:0]  rem_reg   [QW];
    logic [LANES-1:0][VW-1:0]  dvs_reg   [QW];
    logic [LANES-1:0][QW-1:0]  quo_reg   [QW];
    logic [SW-1:0]             side_reg  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        logic                      v_src;
        logic [LANES-1:0][WW-1:0]  rem_src;
        logic [LANES-1:0][WW-1:0]  rem_next;
        logic [LANES-1:0][VW-1:0]  dvs_src;
        logic [LANES-1:0][QW-1:0]  quo_src;
        logic [LANES-1:0][QW-1:0]  quo_next;
        logic [SW-1:0]             side_src;

        if (s == 0) begin : g_first
            always_comb
            begin
                v_src    = in_valid;
                side_src = side_in;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l] = WW'(dividend[l]);
                    dvs_src[l] = divisor[l];
                    quo_src[l] = '0;
                end
            end
        end else begin : g_later
            always_comb
            begin
                v_src    = valid_reg[s-1];
                side_src = side_reg[s-1];
                rem_src  = rem_reg[s-1];
                dvs_src  = dvs_reg[s-1];
                quo_src  = quo_reg[s-1];
            end
        end

        always_comb
        begin
            logic [WW-1:0] shifted;
            for (int l = 0; l < LANES; l++)
            begin
                shifted     = WW'(dvs_src[l]) << B;
                quo_next[l] = quo_src[l];
                if (rem_src[l] >= shifted)
                begin
                    rem_next[l]    = rem_src[l] - shifted;
                    quo_next[l][B] = 1'b1;
                end
                else
                begin
                    rem_next[l] = rem_src[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                dvs_reg[s]  <= dvs_src;
                quo_reg[s]  <= quo_next;
                side_reg[s] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quotient  = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

FILE: tb/truth_value_combiner_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// truth_value_combiner_tb: self-checking bench for the truth value combiner
// Drives directed and random operand pairs through the valid/ready input,
// predicts each combined pair in the bench and compares it with every
// transaction that leaves the output channel, under random idling and a long
// receiver stall.
// ============================================================================
module truth_value_combiner_tb;
    import tvc_pkg::*;

    typedef struct {
        logic [15:0] s;
        logic [15:0] c;
        logic        fb;
    } tv_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  cmd;
    logic [15:0] strength_a;
    logic [15:0] conf_a;
    logic [15:0] strength_b;
    logic [15:0] conf_b;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_strength;
    logic [15:0] out_conf;
    logic        fallback;

    // Combined pairs predicted for transactions already accepted, oldest first.
    tv_result_t pending_pairs[$];
    int         error_count;
    int         burst_left;
    // When set, the receiver holds out_ready low for a long stretch.
    bit         hold_receiver;

    truth_value_combiner uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .strength_a(strength_a), .conf_a(conf_a),
        .strength_b(strength_b), .conf_b(conf_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_strength(out_strength), .out_conf(out_conf), .fallback(fallback)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Truncating Q1.15 product, evaluated in 64 bits.
    function automatic logic [63:0] q15_product(input logic [63:0] x, input logic [63:0] y);
        return (x * y) >> 15;
    endfunction

    function automatic logic [63:0] clamp_one(input logic [63:0] v);
        return (v > 64'd32768) ? 64'd32768 : v;
    endfunction

    // Computes the combined truth value exactly as the hardware must.
    function automatic tv_result_t combine_truth(input logic [3:0] op,
                                                 input logic [15:0] ra, input logic [15:0] rca,
                                                 input logic [15:0] rb, input logic [15:0] rcb);
        logic [63:0] sa, ca, sb, cb, rs, rc, d, num, k, n;
        logic [63:0] bel1, dis1, unc1, bel2, dis2, unc2, belc, disc, u;
        logic        fb;
        tv_result_t  r;
        sa = clamp_one(64'(ra));
        ca = clamp_one(64'(rca));
        sb = clamp_one(64'(rb));
        cb = clamp_one(64'(rcb));
        rs = sa;
        rc = ca;
        fb = 1'b0;
        case (op)
            CMD_HICONF: if (!(ca > cb)) begin rs = sb; rc = cb; end
            CMD_LOCONF: if (!(ca < cb)) begin rs = sb; rc = cb; end
            CMD_WAVG:
            begin
                d = ca + cb;
                if (d < 4)
                begin
                    rs = (sa + sb) >> 1; rc = 0; fb = 1'b1;
                end
                else
                begin
                    rs = (sa * ca + sb * cb) / d;
                    rc = (ca > cb) ? ca : cb;
                end
            end
            CMD_REVISE:
            begin
                d = ca + cb - q15_product(ca, cb);
                if (d < 4)
                begin
                    rs = (sa + sb) >> 1; rc = 0; fb = 1'b1;
                end
                else
                begin
                    num = q15_product(sa, ca) * (32768 - cb)
                        + q15_product(sb, cb) * (32768 - ca)
                        + q15_product(sa, sb) * q15_product(ca, cb);
                    rs = num / d;
                    rc = d;
                end
            end
            CMD_DS:
            begin
                bel1 = q15_product(sa, ca);
                dis1 = q15_product(32768 - sa, ca);
                unc1 = 32768 - ca;
                bel2 = q15_product(sb, cb);
                dis2 = q15_product(32768 - sb, cb);
                unc2 = 32768 - cb;
                k = q15_product(bel1, dis2) + q15_product(dis1, bel2);
                if (k > 32440)
                begin
                    rs = 16384; rc = 0; fb = 1'b1;
                end
                else
                begin
                    n = 32768 - k;
                    belc = ((q15_product(bel1, bel2) + q15_product(bel1, unc2)
                           + q15_product(unc1, bel2)) << 15) / n;
                    disc = ((q15_product(dis1, dis2) + q15_product(dis1, unc2)
                           + q15_product(unc1, dis2)) << 15) / n;
                    u = (q15_product(unc1, unc2) << 15) / n;
                    rs = (belc << 15) / (belc + disc + 3);
                    rc = (u > 32768) ? 0 : 32768 - u;
                end
            end
            CMD_MAXS: if (!(sa > sb)) begin rs = sb; rc = cb; end
            CMD_MINS: if (!(sa < sb)) begin rs = sb; rc = cb; end
            CMD_DEDUCT:
            begin
                rs = q15_product(sa, sb);
                rc = q15_product(ca, cb);
            end
            CMD_INDUCT:
            begin
                rs = q15_product(sa, sb) + q15_product(32768 - sa, 32768 - sb);
                rc = q15_product(ca, cb) >> 1;
            end
            CMD_ABDUCT:
            begin
                rs = q15_product(sa, sb);
                rc = q15_product(q15_product(ca, cb), 9830);
            end
            default: ;
        endcase
        r.s = 16'(clamp_one(rs));
        r.c = 16'(clamp_one(rc));
        r.fb = fb;
        return r;
    endfunction

    // Offers one transaction, honoring a random burst/gap pattern, and
    // records its prediction at the accepting edge.
    task automatic send_pair(input logic [3:0] op, input logic [15:0] sa, input logic [15:0] ca,
                             input logic [15:0] sb, input logic [15:0] cb);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= op;
        strength_a <= sa;
        conf_a     <= ca;
        strength_b <= sb;
        conf_b     <= cb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_pairs.push_back(combine_truth(op, sa, ca, sb, cb));
        if (burst_left == 0 || $urandom_range(0, 3) != 0)
            ; // valid stays high into the next call or the gap lowers it
    endtask

    // Leaves the input channel quiet once the stimulus is done.
    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random Q1.15 operand weighted toward the range edges, at times above one.
    function automatic logic [15:0] random_q15();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(0, 8));
            3: return 16'($urandom_range(32760, 32768));
            4: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic test_selections();
        send_pair(CMD_HICONF, 16'd1000, 16'd20000, 16'd2000, 16'd20000);
        send_pair(CMD_HICONF, 16'd1000, 16'd20001, 16'd2000, 16'd20000);
        send_pair(CMD_LOCONF, 16'd1000, 16'd5, 16'd2000, 16'd5);
        send_pair(CMD_LOCONF, 16'd1000, 16'd4, 16'd2000, 16'd5);
        send_pair(CMD_MAXS, 16'd7000, 16'd1, 16'd7000, 16'd2);
        send_pair(CMD_MAXS, 16'd32768, 16'd1, 16'd0, 16'd2);
        send_pair(CMD_MINS, 16'd7000, 16'd1, 16'd7000, 16'd2);
        send_pair(CMD_MINS, 16'd0, 16'd1, 16'd32768, 16'd2);
    endtask

    task automatic test_arithmetic();
        // Small denominators take the fallback path in averaging and revision.
        send_pair(CMD_WAVG, 16'd32768, 16'd1, 16'd100, 16'd2);
        send_pair(CMD_WAVG, 16'd32768, 16'd2, 16'd100, 16'd2);
        send_pair(CMD_REVISE, 16'd5, 16'd0, 16'd8, 16'd3);
        send_pair(CMD_REVISE, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
        // Total conflict in the evidence fusion, then a mild case and all zeros.
        send_pair(CMD_DS, 16'd32768, 16'd32768, 16'd0, 16'd32768);
        send_pair(CMD_DS, 16'd20000, 16'd16000, 16'd12000, 16'd9000);
        send_pair(CMD_DS, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(CMD_DEDUCT, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
        send_pair(CMD_INDUCT, 16'd0, 16'd32768, 16'd0, 16'd32768);
        send_pair(CMD_ABDUCT, 16'd32768, 16'd32768, 16'd16384, 16'd32768);
        // Operands above one are saturated; unknown codes pass A through.
        send_pair(CMD_DEDUCT, 16'hFFFF, 16'hFFFF, 16'h8001, 16'hFFFF);
        send_pair(4'd10, 16'hFFFF, 16'h1234, 16'd1, 16'd1);
        send_pair(4'd15, 16'd0, 16'd0, 16'd1, 16'd1);
    endtask

    task automatic test_random();
        logic [3:0] op;
        for (int i = 0; i < 420; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            send_pair(op, random_q15(), random_q15(), random_q15(), random_q15());
        end
    endtask

    // Holds the receiver off long enough for the skid stage to fill and
    // in_ready to fall, while the sender keeps offering transactions.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pair(CMD_REVISE, random_q15(), random_q15(), random_q15(), random_q15());
        hold_receiver = 1'b0;
    endtask

    // Receiver: stalls on its own pattern, or for a long counted stretch.
    initial
    begin
        int hold_cycles;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 120)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_receiver = 1'b0;
            end
            else if (($urandom_range(0, 63) < 32) && ($urandom_range(0, 3) != 0))
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Result checker: each accepted output is matched with the oldest prediction.
    always @(posedge clk)
    begin
        tv_result_t exp_pair;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected output transaction s=%0d c=%0d", out_strength, out_conf);
                error_count++;
            end
            else
            begin
                exp_pair = pending_pairs.pop_front();
                if (out_strength !== exp_pair.s)
                begin
                    $error("out_strength expected %0d got %0d", exp_pair.s, out_strength);
                    error_count++;
                end
                if (out_conf !== exp_pair.c)
                begin
                    $error("out_conf expected %0d got %0d", exp_pair.c, out_conf);
                    error_count++;
                end
                if (fallback !== exp_pair.fb)
                begin
                    $error("fallback expected %0d got %0d", exp_pair.fb, fallback);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("truth_value_combiner: mismatch");
        $finish;
    end

    initial
    begin
        int drain;
        error_count   = 0;
        burst_left    = 0;
        hold_receiver = 1'b0;
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        cmd        <= CMD_HICONF;
        strength_a <= 16'd0;
        conf_a     <= 16'd0;
        strength_b <= 16'd0;
        conf_b     <= 16'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_selections();
        test_arithmetic();
        test_backpressure();
        test_random();
        stop_sending();

        // Wait for every prediction to be consumed, then let the pipeline settle.
        drain = 0;
        while (pending_pairs.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (60) @(posedge clk);

        if (error_count == 0 && pending_pairs.size() == 0)
            $display("truth_value_combiner: match");
        else
            $display("truth_value_combiner: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tvc_pkg.sv
rtl/core/tvc_div.sv
rtl/core/truth_value_combiner.sv
tb/truth_value_combiner_tb.sv
